@@ rtl/core/a32c_pkg.sv @@
// Shared constants and a helper function for the eight-byte Adler-32 checksum block.
// No dependencies; every other file in rtl/core refers to this package by scoped names.
`default_nettype none

package a32c_pkg;

	// Adler-32 modulus, and 2^16 reduced modulo that modulus.
	localparam int unsigned ADLER_MOD  = 65521;
	localparam int unsigned ADLER_FOLD = 15;

	localparam int unsigned BYTES_PER_WORD = 8;
	localparam int unsigned LANES_DEF      = 8;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned DATA_W    = 64;
	localparam int unsigned CNT_W     = 4;
	localparam int unsigned SUM_W     = 16;
	localparam int unsigned CSUM_W    = 32;
	// A byte times a weight of at most eight fits in 11 bits.
	localparam int unsigned WBYTE_W   = 11;
	// Up to eight bytes summed: at most 2040.
	localparam int unsigned BSUM_W    = 11;
	// Weighted sum with weights 8 down to 1: at most 36 * 255 = 9180.
	localparam int unsigned WSUM_W    = 14;
	// One bit above a 16-bit sum, enough for a value below twice the modulus.
	localparam int unsigned RED_W     = 17;
	// Raw s2 before reduction: s2 + 8 * s1 + weighted sum stays below 2^20.
	localparam int unsigned S2RAW_W   = 20;

	// Control that goes with one transaction into the accumulate stage.
	typedef struct packed {
		logic load;
		logic last;
	} acc_ctl_t;

	// Reduces a value below twice the modulus with one compare and subtract.
	function automatic logic [SUM_W-1:0] mod_once(input logic [RED_W-1:0] x);
		logic [RED_W-1:0] diff;
		diff = x - RED_W'(ADLER_MOD);
		mod_once = (x >= RED_W'(ADLER_MOD)) ? diff[SUM_W-1:0] : x[SUM_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/a32c_if.sv @@
// Channel interfaces of the Adler-32 block: byte stream, checksum results and seed writes.
// Depends on a32c_pkg for field widths.
`default_nettype none

interface a32c_in_if;
	logic                                valid;
	logic                                ready;
	logic [a32c_pkg::DATA_W-1:0]         data;
	logic [a32c_pkg::CNT_W-1:0]          byte_count;
	logic                                last;

	modport source (output valid, output data, output byte_count, output last, input ready);
	modport sink   (input valid, input data, input byte_count, input last, output ready);
endinterface

interface a32c_out_if;
	logic                                valid;
	logic                                ready;
	logic [a32c_pkg::CSUM_W-1:0]         checksum;
	logic                                final_res;

	modport source (output valid, output checksum, output final_res, input ready);
	modport sink   (input valid, input checksum, input final_res, output ready);
endinterface

interface a32c_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [a32c_pkg::CSUM_W-1:0]         seed;

	modport source (output valid, output seed, input ready);
	modport sink   (input valid, input seed, output ready);
endinterface

`default_nettype wire

@@ rtl/core/a32c_lane.sv @@
// One byte lane: masks its byte by the valid count and forms the byte times its s2 weight.
// Depends on a32c_pkg for widths.
`default_nettype none

module a32c_lane #(
	parameter int unsigned LANE_IDX = 0
) (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic [a32c_pkg::BYTE_W-1:0]       byte_in,
	input  wire logic [a32c_pkg::CNT_W-1:0]        n,
	output logic      [a32c_pkg::BYTE_W-1:0]       byte_s1,
	output logic      [a32c_pkg::WBYTE_W-1:0]      wbyte_s1
);

	logic                                          active;
	logic [a32c_pkg::CNT_W-1:0]                    weight;
	logic [a32c_pkg::BYTE_W-1:0]                   masked;
	logic [a32c_pkg::BYTE_W+a32c_pkg::CNT_W-1:0]   prod;

	// Byte i is added before the remaining n - i additions into s2, so it counts n - i times.
	always_comb begin
		active = n > a32c_pkg::CNT_W'(LANE_IDX);
		weight = n - a32c_pkg::CNT_W'(LANE_IDX);
		masked = active ? byte_in : '0;
		prod   = {{a32c_pkg::CNT_W{1'b0}}, masked} * {{a32c_pkg::BYTE_W{1'b0}}, weight};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			byte_s1  <= masked;
			wbyte_s1 <= prod[a32c_pkg::WBYTE_W-1:0];
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/a32c_merge.sv @@
// Merge stage: adds the lane bytes and the weighted lane bytes into two registered sums.
// Depends on a32c_pkg for widths.
`default_nettype none

module a32c_merge #(
	parameter int unsigned LANES = a32c_pkg::LANES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic [a32c_pkg::BYTE_W-1:0]       byte_s1  [LANES],
	input  wire logic [a32c_pkg::WBYTE_W-1:0]      wbyte_s1 [LANES],
	output logic      [a32c_pkg::BSUM_W-1:0]       bsum_s2,
	output logic      [a32c_pkg::WSUM_W-1:0]       wsum_s2
);

	logic [a32c_pkg::BSUM_W-1:0] bsum;
	logic [a32c_pkg::WSUM_W-1:0] wsum;

	always_comb begin
		bsum = '0;
		wsum = '0;
		for (int unsigned i = 0; i < LANES; i++) begin
			bsum = bsum + a32c_pkg::BSUM_W'(byte_s1[i]);
			wsum = wsum + a32c_pkg::WSUM_W'(wbyte_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bsum_s2 <= bsum;
			wsum_s2 <= wsum;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/a32c_accum.sv @@
// Accumulate: holds s1, s2; on load folds in one merged transaction a cycle, reduces mod 65521.
// Depends on a32c_pkg for widths, the modulus and the reduction function.
`default_nettype none

module a32c_accum (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire a32c_pkg::acc_ctl_t                ctl,
	input  wire logic [a32c_pkg::CNT_W-1:0]        n,
	input  wire logic [a32c_pkg::BSUM_W-1:0]       bsum,
	input  wire logic [a32c_pkg::WSUM_W-1:0]       wsum,
	input  wire logic [a32c_pkg::SUM_W-1:0]        seed_lo,
	input  wire logic [a32c_pkg::SUM_W-1:0]        seed_hi,
	output logic      [a32c_pkg::SUM_W-1:0]        sum_low_q,
	output logic      [a32c_pkg::SUM_W-1:0]        sum_high_q,
	output logic                                   final_q
);

	logic                                in_stream_q;
	logic [a32c_pkg::SUM_W-1:0]          base1;
	logic [a32c_pkg::SUM_W-1:0]          base2;
	logic [a32c_pkg::RED_W-1:0]          s1_raw;
	logic [a32c_pkg::S2RAW_W-1:0]        s2_raw;
	logic [a32c_pkg::RED_W-1:0]          s2_fold;
	logic [a32c_pkg::SUM_W-1:0]          s1_next;
	logic [a32c_pkg::SUM_W-1:0]          s2_next;

	always_comb begin
		// A new stream starts from the seed halves, already reduced when written.
		base1  = in_stream_q ? sum_low_q  : seed_lo;
		base2  = in_stream_q ? sum_high_q : seed_hi;
		s1_raw = a32c_pkg::RED_W'(base1) + a32c_pkg::RED_W'(bsum);
		s2_raw = a32c_pkg::S2RAW_W'(base2)
		       + a32c_pkg::S2RAW_W'(n) * a32c_pkg::S2RAW_W'(base1)
		       + a32c_pkg::S2RAW_W'(wsum);
		// 2^16 is 15 modulo 65521, so the bits above 16 fold back in times 15.
		s2_fold = a32c_pkg::RED_W'(s2_raw[a32c_pkg::SUM_W-1:0])
		        + a32c_pkg::RED_W'(s2_raw[a32c_pkg::S2RAW_W-1:a32c_pkg::SUM_W])
		          * a32c_pkg::RED_W'(a32c_pkg::ADLER_FOLD);
		s1_next = a32c_pkg::mod_once(s1_raw);
		s2_next = a32c_pkg::mod_once(s2_fold);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_low_q   <= '0;
			sum_high_q  <= '0;
			in_stream_q <= 1'b0;
			final_q     <= 1'b0;
		end else if (ctl.load) begin
			sum_low_q   <= s1_next;
			sum_high_q  <= s2_next;
			in_stream_q <= !ctl.last;
			final_q     <= ctl.last;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/adler32_checksum_8byte.sv @@
// Top level of the eight-byte-per-cycle Adler-32 checksum: lanes, merge and accumulate stages.
// Depends on a32c_pkg, the channel interfaces in a32c_if.sv, a32c_lane, a32c_merge, a32c_accum.
//
//   Channel   Dir   Carries                                  Transaction when
//   -------   ---   --------------------------------------   -------------------------
//   stream    in    data[63:0], byte_count[3:0], last        stream.valid & stream.ready
//   result    out   checksum[31:0], final_res                result.valid & result.ready
//   cfg       in    seed[31:0]                               cfg.valid & cfg.ready
//
// Every accepted stream transaction produces exactly one result, after the lane, merge and
// accumulate registers. One transaction enters per cycle while the output side is not stalled;
// that rate is set by the s1/s2 update in the accumulate stage, whose loop holds one 4x16
// multiply and two compare-and-subtract reductions.
// Reset (arst_n low) empties the pipeline, clears s1, s2 and the open-stream flag, and sets the
// seed to 1. A stalled result holds the output register while the lane and merge stages keep
// filling, so up to three transactions are held before stream.ready drops.
`default_nettype none

module adler32_checksum_8byte #(
	parameter int unsigned LANES = a32c_pkg::LANES_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	a32c_in_if.sink           stream,
	a32c_out_if.source        result,
	a32c_cfg_if.sink          cfg
);

	// Bytes beyond the eighth do not exist, so lanes past eight would never be active.
	localparam int unsigned EffLanes =
		(LANES > a32c_pkg::BYTES_PER_WORD) ? a32c_pkg::BYTES_PER_WORD : LANES;

	// Handshake state of the three stages.
	logic v_s1;
	logic v_s2;
	logic out_v_q;
	logic out_take;
	logic s2_en;
	logic s1_en;

	// Count and last mark travel beside the lane data.
	logic [a32c_pkg::CNT_W-1:0]   n_sat;
	logic [a32c_pkg::CNT_W-1:0]   n_s1;
	logic [a32c_pkg::CNT_W-1:0]   n_s2;
	logic                         last_s1;
	logic                         last_s2;

	// Seed halves, stored already reduced modulo 65521.
	logic [a32c_pkg::SUM_W-1:0]   seed_lo_q;
	logic [a32c_pkg::SUM_W-1:0]   seed_hi_q;

	logic [a32c_pkg::BYTE_W-1:0]  byte_s1  [EffLanes];
	logic [a32c_pkg::WBYTE_W-1:0] wbyte_s1 [EffLanes];
	logic [a32c_pkg::BSUM_W-1:0]  bsum_s2;
	logic [a32c_pkg::WSUM_W-1:0]  wsum_s2;

	a32c_pkg::acc_ctl_t           acc_ctl;
	logic [a32c_pkg::SUM_W-1:0]   sum_low;
	logic [a32c_pkg::SUM_W-1:0]   sum_high;
	logic                         final_flag;

	// Each stage moves forward when it is empty or when the stage after it moves, so bubbles
	// collapse and new transactions are taken while a result waits at the output.
	always_comb begin
		out_take = !out_v_q || result.ready;
		s2_en    = !v_s2 || out_take;
		s1_en    = !v_s1 || s2_en;
		// A count above the number of lanes is clipped to the number of lanes.
		n_sat    = (stream.byte_count > a32c_pkg::CNT_W'(EffLanes))
		           ? a32c_pkg::CNT_W'(EffLanes) : stream.byte_count;
		acc_ctl.load = out_take && v_s2;
		acc_ctl.last = last_s2;
	end

	assign stream.ready = s1_en;
	assign cfg.ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s1_en) begin
				v_s1 <= stream.valid;
			end
			if (s2_en) begin
				v_s2 <= v_s1;
			end
			if (out_take) begin
				out_v_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_en) begin
			n_s1    <= n_sat;
			last_s1 <= stream.last;
		end
		if (s2_en) begin
			n_s2    <= n_s1;
			last_s2 <= last_s1;
		end
	end

	// The seed takes effect at the next stream start; reset value is s1 = 1, s2 = 0.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_lo_q <= a32c_pkg::SUM_W'(1);
			seed_hi_q <= '0;
		end else if (cfg.valid) begin
			seed_lo_q <= a32c_pkg::mod_once({1'b0, cfg.seed[a32c_pkg::SUM_W-1:0]});
			seed_hi_q <= a32c_pkg::mod_once({1'b0, cfg.seed[a32c_pkg::CSUM_W-1:a32c_pkg::SUM_W]});
		end
	end

	// Lane i takes byte i, the first byte sitting in the top bits of data.
	for (genvar i = 0; i < EffLanes; i++) begin : g_lane
		a32c_lane #(
			.LANE_IDX (i)
		) u_lane (
			.clk      (clk),
			.en       (s1_en),
			.byte_in  (stream.data[a32c_pkg::DATA_W-1-a32c_pkg::BYTE_W*i -: a32c_pkg::BYTE_W]),
			.n        (n_sat),
			.byte_s1  (byte_s1[i]),
			.wbyte_s1 (wbyte_s1[i])
		);
	end

	a32c_merge #(
		.LANES (EffLanes)
	) u_merge (
		.clk      (clk),
		.en       (s2_en),
		.byte_s1  (byte_s1),
		.wbyte_s1 (wbyte_s1),
		.bsum_s2  (bsum_s2),
		.wsum_s2  (wsum_s2)
	);

	a32c_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (acc_ctl),
		.n          (n_s2),
		.bsum       (bsum_s2),
		.wsum       (wsum_s2),
		.seed_lo    (seed_lo_q),
		.seed_hi    (seed_hi_q),
		.sum_low_q  (sum_low),
		.sum_high_q (sum_high),
		.final_q    (final_flag)
	);

	// The running sums change only when a new result loads, so they serve as the output register.
	assign result.valid     = out_v_q;
	assign result.checksum  = {sum_high, sum_low};
	assign result.final_res = final_flag;

endmodule

`default_nettype wire
